FILE: hdl/grid_point_rotate_project_unit_assert.svh
// Assertion macros used by the checker file of the point projector.
`ifndef GRID_POINT_ROTATE_PROJECT_UNIT_ASSERT_SVH
`define GRID_POINT_ROTATE_PROJECT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gprp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GPRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gprp: next-cycle check failed");

`endif

FILE: hdl/gprp_pkg.sv
// ----------------------------------------------------------------------------
// gprp_pkg
// Shared types, widths and helper functions of the grid point projector.
// ----------------------------------------------------------------------------
`default_nettype none

package gprp_pkg;

	// register stages from input capture up to and including the output register
	localparam int PIPE_DEPTH = 8;

	localparam int ANGLE_W  = 10;
	localparam int ZOOM_W   = 16;
	localparam int OFS_W    = 16;
	localparam int GRID_W   = 11;
	localparam int HSUM_W   = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int COL_W   = 10;
	localparam int HGT_W   = 16;
	localparam int COLOR_W = 24;
	localparam int IN_W    = 64;

	localparam int OUT_W   = 24;
	localparam int OUT_BUS_W = 96;

	// half-unit centred coordinates
	localparam int HXW = 13;
	localparam int HZW = 18;

	// rotated Q.8 coordinates: bounded by (131070 + 2047) * 2 * 2^7 for any trig precision
	localparam int R8W = 26;
	// zoom product
	localparam int ZPW = R8W + ZOOM_W + 1;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PITCH_ANGLE     = 3'd0,
		CFG_YAW_ANGLE       = 3'd1,
		CFG_ZOOM            = 3'd2,
		CFG_SCREEN_OFFSET_X = 3'd3,
		CFG_SCREEN_OFFSET_Y = 3'd4,
		CFG_GRID_COLUMNS    = 3'd5,
		CFG_GRID_ROWS       = 3'd6,
		CFG_HEIGHT_SUM      = 3'd7
	} cfg_reg_t;

	// Taylor series of sine in Q30, nine terms; elaboration time only
	function automatic longint sin_taylor_q30(input longint x);
		longint x2;
		longint term;
		longint sum;
		x2   = x * x / ONE_Q30;
		term = x;
		sum  = x;
		term = -(term * x2 / ONE_Q30) / 6;   sum = sum + term;
		term = -(term * x2 / ONE_Q30) / 20;  sum = sum + term;
		term = -(term * x2 / ONE_Q30) / 42;  sum = sum + term;
		term = -(term * x2 / ONE_Q30) / 72;  sum = sum + term;
		term = -(term * x2 / ONE_Q30) / 110; sum = sum + term;
		term = -(term * x2 / ONE_Q30) / 156; sum = sum + term;
		term = -(term * x2 / ONE_Q30) / 210; sum = sum + term;
		term = -(term * x2 / ONE_Q30) / 272; sum = sum + term;
		return sum;
	endfunction

	// clamp to the signed output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ZPW-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > ZPW'(OUT_MAX))
			r = OUT_MAX;
		else if (v < ZPW'(OUT_MIN))
			r = OUT_MIN;
		else
			r = OUT_W'(v);
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/grid_point_rotate_project_unit.sv
// ----------------------------------------------------------------------------
// grid_point_rotate_project_unit
// Height-map point rotation (yaw, then pitch) and screen projection.
// ----------------------------------------------------------------------------
// One point per clock: the datapath is an eight-stage pipeline (capture,
// centring, yaw products, yaw sums, pitch products, pitch sums and rounding,
// zoom products, offset and saturation), and the result is registered in the
// last stage before it is shown on m_axis; the block sustains one transfer
// per cycle on both sides; it only stops when m_axis_tready is held low and
// every stage fills.
// Sine and cosine come from a quarter-wave ROM built at elaboration; angle
// reduction and ROM lookup run in two register stages off the angle
// registers, so an angle write applies to every point transferred after it.
// No clearing pass is needed after reset.
`default_nettype none

module grid_point_rotate_project_unit
	import gprp_pkg::*;
#(
	parameter int ANGLE_STEPS    = 1024,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// grid_col[9:0], grid_row[19:10], height[35:20], point_color[59:36], zero pad
	input  wire logic [IN_W-1:0]       s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// screen_x[23:0], screen_y[47:24], rotated_depth[71:48], out_color[95:72]
	output logic [OUT_BUS_W-1:0]       m_axis_tdata
);

	localparam int F        = TRIG_FRAC_BITS;
	localparam int QUARTER  = ANGLE_STEPS / 4;
	localparam int ROM_SIZE = QUARTER + 1;
	localparam int ROMW     = F + 1;
	localparam int IW       = $clog2(ROM_SIZE);
	localparam int AW       = $clog2(ANGLE_STEPS);
	localparam int WW       = ((ANGLE_W > AW + 4) ? ANGLE_W : AW + 4) + 1;
	localparam int TW       = F + 2;
	localparam int YXW      = TW + HXW;
	localparam int YZW      = TW + HZW;
	localparam int RW       = TW + HZW;
	localparam int QW       = TW + RW;
	localparam int SH       = 2 * F - 7;

	// ---------------------------------------------------------------- sine ROM
	logic [ROMW-1:0] sin_rom [ROM_SIZE];

	for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
		localparam longint X     = HALF_PI_Q30 * k / QUARTER;
		localparam longint SUM   = sin_taylor_q30(X);
		localparam longint SUMC  = (SUM < 0) ? 64'sd0 : SUM;
		localparam longint ONE_F = 64'sd1 <<< F;
		localparam longint V0    = (SUMC * ONE_F + ONE_Q30 / 2) / ONE_Q30;
		localparam longint V     = (V0 > ONE_F) ? ONE_F : V0;
		assign sin_rom[k] = ROMW'(V);
	end

	// --------------------------------------------------------- config registers
	logic        [ANGLE_W-1:0] pitch_q;
	logic        [ANGLE_W-1:0] yaw_q;
	logic        [ZOOM_W-1:0]  zoom_q;
	logic signed [OFS_W-1:0]   ofs_x_q;
	logic signed [OFS_W-1:0]   ofs_y_q;
	logic        [GRID_W-1:0]  cols_q;
	logic        [GRID_W-1:0]  rows_q;
	logic signed [HSUM_W-1:0]  hsum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			yaw_q   <= '0;
			zoom_q  <= ZOOM_W'(256);
			ofs_x_q <= '0;
			ofs_y_q <= '0;
			cols_q  <= GRID_W'(1);
			rows_q  <= GRID_W'(1);
			hsum_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_wr_index))
				CFG_PITCH_ANGLE:     pitch_q <= cfg_wr_data[ANGLE_W-1:0];
				CFG_YAW_ANGLE:       yaw_q   <= cfg_wr_data[ANGLE_W-1:0];
				CFG_ZOOM:            zoom_q  <= cfg_wr_data[ZOOM_W-1:0];
				CFG_SCREEN_OFFSET_X: ofs_x_q <= $signed(cfg_wr_data[OFS_W-1:0]);
				CFG_SCREEN_OFFSET_Y: ofs_y_q <= $signed(cfg_wr_data[OFS_W-1:0]);
				CFG_GRID_COLUMNS:    cols_q  <= cfg_wr_data[GRID_W-1:0];
				CFG_GRID_ROWS:       rows_q  <= cfg_wr_data[GRID_W-1:0];
				CFG_HEIGHT_SUM:      hsum_q  <= $signed(cfg_wr_data[HSUM_W-1:0]);
			endcase
		end
	end

	// ------------------------------------------------------------ trig lookup
	// angle modulo ANGLE_STEPS by restoring subtraction (quotient below 16)
	function automatic logic [AW-1:0] wrap_angle(input logic [ANGLE_W-1:0] ang);
		logic [WW-1:0] t;
		t = WW'(ang);
		for (int j = 3; j >= 0; j--) begin
			if (t >= (WW'(ANGLE_STEPS) << j))
				t = t - (WW'(ANGLE_STEPS) << j);
		end
		return AW'(t);
	endfunction

	function automatic logic [AW-1:0] cos_angle(input logic [AW-1:0] a);
		logic [AW:0] c;
		c = {1'b0, a} + (AW+1)'(QUARTER);
		if (c >= (AW+1)'(ANGLE_STEPS))
			c = c - (AW+1)'(ANGLE_STEPS);
		return AW'(c);
	endfunction

	// {negate, ROM index} for a reduced angle
	function automatic logic [IW:0] quad_sel(input logic [AW-1:0] a);
		logic [AW-1:0] x;
		logic          hi;
		logic          lo;
		logic [IW-1:0] idx;
		hi  = (a >= AW'(2 * QUARTER));
		x   = hi ? a - AW'(2 * QUARTER) : a;
		lo  = (x >= AW'(QUARTER));
		x   = lo ? x - AW'(QUARTER) : x;
		idx = lo ? IW'(QUARTER) - IW'(x) : IW'(x);
		return {hi, idx};
	endfunction

	function automatic logic signed [TW-1:0] rom_val(input logic [IW:0] sel,
		input logic [ROMW-1:0] mag);
		logic signed [TW-1:0] v;
		v = $signed({1'b0, mag});
		return sel[IW] ? -v : v;
	endfunction

	logic [AW-1:0] yaw_red;
	logic [AW-1:0] pitch_red;

	assign yaw_red   = wrap_angle(yaw_q);
	assign pitch_red = wrap_angle(pitch_q);

	logic [IW:0] sel_sy_q, sel_cy_q, sel_sp_q, sel_cp_q;
	logic signed [TW-1:0] sin_yaw_q, cos_yaw_q, sin_pitch_q, cos_pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_sy_q    <= '0;
			sel_cy_q    <= '0;
			sel_sp_q    <= '0;
			sel_cp_q    <= '0;
			sin_yaw_q   <= '0;
			cos_yaw_q   <= '0;
			sin_pitch_q <= '0;
			cos_pitch_q <= '0;
		end else begin
			sel_sy_q    <= quad_sel(yaw_red);
			sel_cy_q    <= quad_sel(cos_angle(yaw_red));
			sel_sp_q    <= quad_sel(pitch_red);
			sel_cp_q    <= quad_sel(cos_angle(pitch_red));
			sin_yaw_q   <= rom_val(sel_sy_q, sin_rom[sel_sy_q[IW-1:0]]);
			cos_yaw_q   <= rom_val(sel_cy_q, sin_rom[sel_cy_q[IW-1:0]]);
			sin_pitch_q <= rom_val(sel_sp_q, sin_rom[sel_sp_q[IW-1:0]]);
			cos_pitch_q <= rom_val(sel_cp_q, sin_rom[sel_cp_q[IW-1:0]]);
		end
	end

	// ------------------------------------------------------------ flow control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	assign rdy_s8 = !vld_s8 || m_axis_tready;
	assign rdy_s7 = !vld_s7 || rdy_s8;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign s_axis_tready = rdy_s1;
	assign m_axis_tvalid = vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_axis_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
		end
	end

	// ---------------------------------------------------------------- datapath
	logic        [COL_W-1:0]   col_s1, row_s1;
	logic signed [HGT_W-1:0]   hgt_s1;
	logic        [COLOR_W-1:0] color_s1, color_s2, color_s3, color_s4;
	logic        [COLOR_W-1:0] color_s5, color_s6, color_s7, color_s8;

	logic signed [HXW-1:0] hx_s2, hy_s2, hy_s3, hy_s4;
	logic signed [HZW-1:0] hz_s2;

	logic signed [YZW-1:0] sy_hz_s3, cy_hz_s3;
	logic signed [YXW-1:0] cy_hx_s3, sy_hx_s3;

	logic signed [RW-1:0] rx_s4, rz1_s4, rx_s5;

	logic signed [YXW-1:0] cp_hy_s5, sp_hy_s5;
	logic signed [QW-1:0]  sp_rz_s5, cp_rz_s5;

	logic signed [R8W-1:0] rx8_s6, ry8_s6, rz8_s6;

	logic signed [ZPW-1:0]   zx_s7, zy_s7;
	logic signed [OUT_W-1:0] rz_s7, rz_s8, sx_s8, sy_s8;

	// pitch sums and rounding to Q.8
	logic signed [QW-1:0] ry_c, rz_c, ry_r, rz_r;
	logic signed [RW-1:0] rx_r;

	always_comb begin
		ry_c = (QW'(cp_hy_s5) <<< F) - sp_rz_s5;
		rz_c = (QW'(sp_hy_s5) <<< F) + cp_rz_s5;
		ry_r = (ry_c + (QW'(1) <<< (SH - 1))) >>> SH;
		rz_r = (rz_c + (QW'(1) <<< (SH - 1))) >>> SH;
		// rx carries only 2^F, so its rounding point sits F bits lower
		rx_r = (rx_s5 + (RW'(1) <<< (F - 8))) >>> (F - 7);
	end

	// zoom rounding and offset
	logic signed [ZPW-1:0] sx_c, sy_c;

	always_comb begin
		sx_c = ((zx_s7 + ZPW'(128)) >>> 8) + (ZPW'(ofs_x_q) <<< 8);
		sy_c = ((zy_s7 + ZPW'(128)) >>> 8) + (ZPW'(ofs_y_q) <<< 8);
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			col_s1   <= s_axis_tdata[9:0];
			row_s1   <= s_axis_tdata[19:10];
			hgt_s1   <= $signed(s_axis_tdata[35:20]);
			color_s1 <= s_axis_tdata[59:36];
		end
		if (rdy_s2) begin
			hx_s2    <= $signed({2'b00, col_s1, 1'b0}) - ($signed({2'b00, cols_q}) - HXW'(1));
			hy_s2    <= $signed({2'b00, row_s1, 1'b0}) - ($signed({2'b00, rows_q}) - HXW'(1));
			hz_s2    <= $signed({hgt_s1[HGT_W-1], hgt_s1, 1'b0})
				- $signed({hsum_q[HSUM_W-1], hsum_q});
			color_s2 <= color_s1;
		end
		if (rdy_s3) begin
			sy_hz_s3 <= YZW'(sin_yaw_q) * YZW'(hz_s2);
			cy_hz_s3 <= YZW'(cos_yaw_q) * YZW'(hz_s2);
			cy_hx_s3 <= YXW'(cos_yaw_q) * YXW'(hx_s2);
			sy_hx_s3 <= YXW'(sin_yaw_q) * YXW'(hx_s2);
			hy_s3    <= hy_s2;
			color_s3 <= color_s2;
		end
		if (rdy_s4) begin
			rx_s4    <= RW'(sy_hz_s3) + RW'(cy_hx_s3);
			rz1_s4   <= RW'(cy_hz_s3) - RW'(sy_hx_s3);
			hy_s4    <= hy_s3;
			color_s4 <= color_s3;
		end
		if (rdy_s5) begin
			cp_hy_s5 <= YXW'(cos_pitch_q) * YXW'(hy_s4);
			sp_hy_s5 <= YXW'(sin_pitch_q) * YXW'(hy_s4);
			sp_rz_s5 <= QW'(sin_pitch_q) * QW'(rz1_s4);
			cp_rz_s5 <= QW'(cos_pitch_q) * QW'(rz1_s4);
			rx_s5    <= rx_s4;
			color_s5 <= color_s4;
		end
		if (rdy_s6) begin
			rx8_s6   <= R8W'(rx_r);
			ry8_s6   <= R8W'(ry_r);
			rz8_s6   <= R8W'(rz_r);
			color_s6 <= color_s5;
		end
		if (rdy_s7) begin
			zx_s7    <= ZPW'(rx8_s6) * ZPW'($signed({1'b0, zoom_q}));
			zy_s7    <= ZPW'(ry8_s6) * ZPW'($signed({1'b0, zoom_q}));
			rz_s7    <= sat_out(ZPW'(rz8_s6));
			color_s7 <= color_s6;
		end
		if (rdy_s8) begin
			sx_s8    <= sat_out(sx_c);
			sy_s8    <= sat_out(sy_c);
			rz_s8    <= rz_s7;
			color_s8 <= color_s7;
		end
	end

	assign m_axis_tdata = {color_s8, rz_s8, sy_s8, sx_s8};

endmodule

`default_nettype wire

FILE: hdl/gprp_checker.sv
// ----------------------------------------------------------------------------
// gprp_checker
// Port-level checks on the point projector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_point_rotate_project_unit_assert.svh"

module gprp_checker
	import gprp_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_axis_tvalid,
	input wire logic                 s_axis_tready,
	input wire logic                 m_axis_tvalid,
	input wire logic                 m_axis_tready,
	input wire logic [OUT_BUS_W-1:0] m_axis_tdata
);

	localparam int CW = $clog2(PIPE_DEPTH + 1) + 1;

	logic          in_xfer;
	logic          out_xfer;
	logic [CW-1:0] inflight_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// points accepted whose result has not yet been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_xfer && !out_xfer)
			inflight_q <= inflight_q + CW'(1);
		else if (!in_xfer && out_xfer)
			inflight_q <= inflight_q - CW'(1);
	end

	`GPRP_ASSERT_NOW(a_no_spurious_result, clk, arst_n, m_axis_tvalid, inflight_q != '0)
	`GPRP_ASSERT_NOW(a_depth_bound, clk, arst_n, 1'b1, inflight_q <= CW'(PIPE_DEPTH))
	`GPRP_ASSERT_NOW(a_ready_follows_sink, clk, arst_n, m_axis_tready, s_axis_tready)
	`GPRP_ASSERT_NEXT(a_stall_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind grid_point_rotate_project_unit gprp_checker u_gprp_checker (.*);

`default_nettype wire
